// ===== rtl/xcfd_pkg.sv =====
// Shared types and constants for the XOR-checked frame deframer.
// Holds phase codes, status codes, register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package xcfd_pkg;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 2;
	localparam int PHASE_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Hard ceiling on the announced payload length
	localparam logic [LEN_W-1:0] LENGTH_LIMIT = 16'hFFFF;

	// Receive phases
	localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENHI = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENLO = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;
	localparam logic [PHASE_W-1:0] PH_END1  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_END2  = 3'd7;

	// Frame status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADLEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADEND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADSUM = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_ONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_TWO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd4;

	// Reset values of the configuration registers
	localparam logic [BYTE_W-1:0] RST_START_ONE = 8'hA0;
	localparam logic [BYTE_W-1:0] RST_START_TWO = 8'hA1;
	localparam logic [BYTE_W-1:0] RST_END_ONE   = 8'h0D;
	localparam logic [BYTE_W-1:0] RST_END_TWO   = 8'h0A;
	localparam logic [LEN_W-1:0]  RST_MAX_LEN   = 16'hFFFF;

	// One result transaction
	typedef struct packed {
		logic                payload_valid;
		logic [BYTE_W-1:0]   payload_byte;
		logic                payload_last;
		logic                frame_done;
		logic [STATUS_W-1:0] frame_status;
		logic [LEN_W-1:0]    frame_length;
	} result_t;

endpackage

// ===== rtl/xor_checked_frame_deframer_top.sv =====
// XOR-checked, length-prefixed frame deframer: start-byte hunt, length header,
// payload pass-through with last mark, checksum and end-byte check.
// A result passes the stage 1 input register and the stage 2 output register on its way to m_tvalid.
// Throughput: one byte per cycle; a low
// m_tready holds both stages and s_tready drops once both are full.
// Reset (arst_n low, asynchronous): hunting for the first start byte, pipeline
// empty, configuration back to 0xA0 / 0xA1 / 0x0D / 0x0A / 65535.
// Depends on xcfd_pkg.
`timescale 1ns / 1ps

module xor_checked_frame_deframer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xcfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Received bytes
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] in_byte
	// Results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // [7:0] payload_byte, [23:8] frame_length
	output logic                              m_tlast,   // payload_last
	output logic [3:0]                        m_tuser    // [0] payload_valid, [1] frame_done,
	                                                     // [3:2] frame_status
);

	import xcfd_pkg::*;

	// Configuration registers
	logic [BYTE_W-1:0] start_one_q, start_two_q, end_one_q, end_two_q;
	logic [LEN_W-1:0]  max_len_q;

	// Deframer state
	logic [PHASE_W-1:0] phase_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   count_q;
	logic [BYTE_W-1:0]  xor_q;
	logic [BYTE_W-1:0]  check_q;
	logic               end_bad_q;

	// Pipeline registers
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;

	// Next-state and result logic
	logic               advance;
	logic               fire_s1;
	logic [PHASE_W-1:0] phase_d;
	logic [LEN_W-1:0]   len_d;
	logic [LEN_W-1:0]   count_d;
	logic [BYTE_W-1:0]  xor_d;
	logic [BYTE_W-1:0]  check_d;
	logic               end_bad_d;
	logic [LEN_W-1:0]   len_full;
	logic [LEN_W-1:0]   count_inc;
	result_t            res_d;

	// Output register moves when empty or taken; stage 1 moves with it
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire_s1  = valid_s1 && advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_one_q <= RST_START_ONE;
			start_two_q <= RST_START_TWO;
			end_one_q   <= RST_END_ONE;
			end_two_q   <= RST_END_TWO;
			max_len_q   <= RST_MAX_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ONE: start_one_q <= cfg_data[BYTE_W-1:0];
				REG_START_TWO: start_two_q <= cfg_data[BYTE_W-1:0];
				REG_END_ONE:   end_one_q   <= cfg_data[BYTE_W-1:0];
				REG_END_TWO:   end_two_q   <= cfg_data[BYTE_W-1:0];
				REG_MAX_LEN:   max_len_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign len_full  = {len_q[LEN_W-1:BYTE_W], byte_s1};
	assign count_inc = count_q + LEN_W'(1);

	// Decode one byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		count_d   = count_q;
		xor_d     = xor_q;
		check_d   = check_q;
		end_bad_d = end_bad_q;
		res_d     = '0;
		unique case (phase_q)
			PH_HUNT1: begin
				if (byte_s1 == start_one_q) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (byte_s1 == start_two_q) phase_d = PH_LENHI;
				else if (byte_s1 == start_one_q) phase_d = PH_HUNT2;
				else phase_d = PH_HUNT1;
			end
			PH_LENHI: begin
				len_d   = {byte_s1, {BYTE_W{1'b0}}};
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d = len_full;
				if (len_full == '0 || len_full > LENGTH_LIMIT || len_full > max_len_q) begin
					res_d.frame_done   = 1'b1;
					res_d.frame_status = ST_BADLEN;
					res_d.frame_length = len_full;
					phase_d            = PH_HUNT1;
				end else begin
					count_d = '0;
					xor_d   = '0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = byte_s1;
				res_d.frame_length  = len_q;
				xor_d               = xor_q ^ byte_s1;
				count_d             = count_inc;
				if (count_inc >= len_q) begin
					res_d.payload_last = 1'b1;
					phase_d            = PH_CHECK;
				end
			end
			PH_CHECK: begin
				check_d = byte_s1;
				phase_d = PH_END1;
			end
			PH_END1: begin
				end_bad_d = (byte_s1 != end_one_q);
				phase_d   = PH_END2;
			end
			PH_END2: begin
				res_d.frame_done   = 1'b1;
				res_d.frame_length = len_q;
				if (end_bad_q || byte_s1 != end_two_q) res_d.frame_status = ST_BADEND;
				else if (xor_q != check_q) res_d.frame_status = ST_BADSUM;
				else res_d.frame_status = ST_OK;
				phase_d = PH_HUNT1;
			end
			default: phase_d = PH_HUNT1;
		endcase
	end

	// Advance deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT1;
			len_q     <= '0;
			count_q   <= '0;
			xor_q     <= '0;
			check_q   <= '0;
			end_bad_q <= 1'b0;
		end else if (fire_s1) begin
			phase_q   <= phase_d;
			len_q     <= len_d;
			count_q   <= count_d;
			xor_q     <= xor_d;
			check_q   <= check_d;
			end_bad_q <= end_bad_d;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.frame_length, res_s2.payload_byte};
	assign m_tlast  = res_s2.payload_last;
	assign m_tuser  = {res_s2.frame_status, res_s2.frame_done, res_s2.payload_valid};

`ifndef SYNTHESIS
	// A result never carries payload and frame end together
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("payload and frame end in one result");

	// Last mark only on payload results
	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("last mark without payload");

	// Nonzero status only on frame end
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3:2] != ST_OK) |-> m_tuser[1])
		else $error("status without frame end");

	// After a frame end the deframer hunts again
	a_hunt_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res_d.frame_done) |=> phase_q == PH_HUNT1)
		else $error("no return to hunting after frame end");

	// Last payload byte moves to the checksum phase
	a_check_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res_d.payload_last) |=> phase_q == PH_CHECK)
		else $error("no checksum phase after last payload byte");
`endif

endmodule
